// ----- sv/dam_pkg.sv -----
`default_nettype none
package dam_pkg;

  localparam int MEM_WORDS = 100;
  localparam int ADDR_W    = $clog2(MEM_WORDS);
  localparam int PC_W      = 7;
  localparam int OP_W      = 7;

  // opcodes
  localparam logic [OP_W-1:0] OP_READ   = 7'd10;
  localparam logic [OP_W-1:0] OP_WRITE  = 7'd11;
  localparam logic [OP_W-1:0] OP_LOAD   = 7'd20;
  localparam logic [OP_W-1:0] OP_STORE  = 7'd21;
  localparam logic [OP_W-1:0] OP_ADD    = 7'd30;
  localparam logic [OP_W-1:0] OP_SUB    = 7'd31;
  localparam logic [OP_W-1:0] OP_DIV    = 7'd32;
  localparam logic [OP_W-1:0] OP_MUL    = 7'd33;
  localparam logic [OP_W-1:0] OP_MOD    = 7'd34;
  localparam logic [OP_W-1:0] OP_POW    = 7'd35;
  localparam logic [OP_W-1:0] OP_BR     = 7'd40;
  localparam logic [OP_W-1:0] OP_BRNEG  = 7'd41;
  localparam logic [OP_W-1:0] OP_BRZERO = 7'd42;
  localparam logic [OP_W-1:0] OP_HALT   = 7'd43;
  localparam logic [OP_W-1:0] OP_STROUT = 7'd90;

  // result status codes
  localparam logic [3:0] ST_LOADED = 4'd0;
  localparam logic [3:0] ST_OK     = 4'd1;
  localparam logic [3:0] ST_WROTE  = 4'd2;
  localparam logic [3:0] ST_READ   = 4'd3;
  localparam logic [3:0] ST_CHAR   = 4'd4;
  localparam logic [3:0] ST_HALT   = 4'd5;
  localparam logic [3:0] ST_DIVZ   = 4'd6;
  localparam logic [3:0] ST_BADOP  = 4'd7;
  localparam logic [3:0] ST_PCOVF  = 4'd8;
  localparam logic [3:0] ST_IDLEH  = 4'd9;

  localparam logic [31:0] DEC_DIVISOR  = 32'd100;
  localparam logic [31:0] CHAR_DIVISOR = 32'd1000;

  // reciprocals, exact for any 32-bit magnitude up to 2^31
  localparam logic [31:0] DEC_RECIP  = 32'd2748779070;  // ceil(2^38 / 100)
  localparam logic [31:0] CHAR_RECIP = 32'd2199023256;  // ceil(2^41 / 1000)
  localparam int          DEC_SHIFT  = 38;
  localparam int          CHAR_SHIFT = 41;

  typedef enum logic [4:0] {
    A_NONE,
    A_CAPTURE,
    A_LOAD,
    A_IDLEH,
    A_PCOVF,
    A_RDPC,
    A_DECST,
    A_DECFIN,
    A_RDAD,
    A_EXEC,
    A_DIVST,
    A_DIVFIN,
    A_DIVZ,
    A_POWINIT,
    A_POWSTEP,
    A_POWFIN,
    A_POWNEG,
    A_OUT
  } act_e;

  typedef struct packed {
    logic            kind;
    logic            halted;
    logic            chars_nz;
    logic            pc_ovf;
    logic            div_done;
    logic [OP_W-1:0] op;
    logic            m_zero;
    logic            m_neg;
    logic            exp_zero;
    logic            out_free;
  } dp_stat_t;

endpackage
`default_nettype wire

// ----- sv/dam_div.sv -----
`default_nettype none
module dam_div (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [31:0] dividend_i,
  input  wire logic [31:0] divisor_i,
  output logic             done_o,
  output logic [31:0]      quo_o,
  output logic [31:0]      rem_o
);

  logic [31:0] rem_q, rem_d, quo_q, quo_d, dvs_q;
  logic [4:0]  cnt_q;
  logic        busy_q, done_q;
  logic [32:0] rem_sh, diff;

  // one quotient bit a cycle, restoring
  always_comb begin
    rem_sh = {rem_q, quo_q[31]};
    diff   = rem_sh - {1'b0, dvs_q};
    if (!diff[32]) begin
      rem_d = diff[31:0];
      quo_d = {quo_q[30:0], 1'b1};
    end else begin
      rem_d = rem_sh[31:0];
      quo_d = {quo_q[30:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule
`default_nettype wire

// ----- sv/dam_ctrl.sv -----
`default_nettype none
module dam_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire dam_pkg::dp_stat_t stat_i,
  output dam_pkg::act_e          act_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DISP  = 4'd1;
  localparam logic [3:0] S_FETCH = 4'd2;
  localparam logic [3:0] S_DEC   = 4'd3;
  localparam logic [3:0] S_ADDR  = 4'd4;
  localparam logic [3:0] S_OPRD  = 4'd5;
  localparam logic [3:0] S_DIV   = 4'd6;
  localparam logic [3:0] S_POW   = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  logic [3:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    act_o   = dam_pkg::A_NONE;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          act_o   = dam_pkg::A_CAPTURE;
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        if (!stat_i.kind) begin
          act_o   = dam_pkg::A_LOAD;
          state_d = S_DONE;
        end else if (stat_i.halted) begin
          act_o   = dam_pkg::A_IDLEH;
          state_d = S_DONE;
        end else if (stat_i.pc_ovf) begin
          act_o   = dam_pkg::A_PCOVF;
          state_d = S_DONE;
        end else begin
          act_o   = dam_pkg::A_RDPC;
          state_d = S_FETCH;
        end
      end
      S_FETCH: begin
        act_o   = dam_pkg::A_DECST;
        state_d = S_DEC;
      end
      S_DEC: begin
        if (stat_i.div_done) begin
          act_o   = dam_pkg::A_DECFIN;
          state_d = stat_i.chars_nz ? S_DONE : S_ADDR;
        end
      end
      S_ADDR: begin
        act_o   = dam_pkg::A_RDAD;
        state_d = S_OPRD;
      end
      S_OPRD: begin
        if (stat_i.op == dam_pkg::OP_DIV || stat_i.op == dam_pkg::OP_MOD) begin
          if (stat_i.m_zero) begin
            act_o   = dam_pkg::A_DIVZ;
            state_d = S_DONE;
          end else begin
            act_o   = dam_pkg::A_DIVST;
            state_d = S_DIV;
          end
        end else if (stat_i.op == dam_pkg::OP_POW) begin
          if (stat_i.m_neg) begin
            act_o   = dam_pkg::A_POWNEG;
            state_d = S_DONE;
          end else begin
            act_o   = dam_pkg::A_POWINIT;
            state_d = S_POW;
          end
        end else begin
          act_o   = dam_pkg::A_EXEC;
          state_d = S_DONE;
        end
      end
      S_DIV: begin
        if (stat_i.div_done) begin
          act_o   = dam_pkg::A_DIVFIN;
          state_d = S_DONE;
        end
      end
      S_POW: begin
        if (stat_i.exp_zero) begin
          act_o   = dam_pkg::A_POWFIN;
          state_d = S_DONE;
        end else begin
          act_o = dam_pkg::A_POWSTEP;
        end
      end
      S_DONE: begin
        if (stat_i.out_free) begin
          act_o   = dam_pkg::A_OUT;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

endmodule
`default_nettype wire

// ----- sv/dam_dp.sv -----
`default_nettype none
module dam_dp (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire dam_pkg::act_e act_i,
  output dam_pkg::dp_stat_t  stat_o,
  input  wire logic          kind_i,
  input  wire logic [6:0]    load_address_i,
  input  wire logic [31:0]   load_value_i,
  input  wire logic [31:0]   read_value_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output logic [3:0]         status_o,
  output logic [31:0]        out_value_o,
  output logic [7:0]         out_char_o,
  output logic               last_char_o,
  output logic [6:0]         pc_now_o,
  output logic [31:0]        acc_now_o
);

  localparam int AW = dam_pkg::ADDR_W;
  localparam int PW = dam_pkg::PC_W;

  logic [31:0] mem_q [dam_pkg::MEM_WORDS];
  logic [dam_pkg::MEM_WORDS-1:0] vld_q;

  logic          kind_q;
  logic [6:0]    ld_addr_q;
  logic [31:0]   ld_val_q, rd_val_q;
  logic [31:0]   acc_q, base_q, res_q, exp_q;
  logic [PW-1:0] pc_q, pc_inc, pc_inc2;
  logic          halted_q;
  logic [6:0]    chars_q;
  logic [dam_pkg::OP_W-1:0] op_q;
  logic [6:0]    ad_q;
  logic [31:0]   rdata_q;
  logic          rvalid_q;
  logic [3:0]    r_status_q;
  logic [31:0]   r_val_q;
  logic [7:0]    r_char_q;
  logic          r_last_q;
  logic          out_valid_q;
  logic [3:0]    o_status_q;
  logic [31:0]   o_val_q, o_acc_q;
  logic [7:0]    o_char_q;
  logic          o_last_q;
  logic [6:0]    o_pc_q;

  logic [31:0] dec_x_q, dec_quo_q, dec_rem_q, dec_quo_d, dec_recip;
  logic [63:0] dec_prod_q;
  logic        dec_wide_q, dec_done_q, dec_start;
  logic [2:0]  dec_stage_q;

  logic [31:0] m, w_abs, acc_abs, m_abs, char_v, quo_s, rem_s;
  logic [31:0] quo, rem;
  logic        div_start, div_done;
  logic        rd_en, we;
  logic [6:0]  ra, wa;
  logic [31:0] wd;
  logic        out_free;

  assign m       = rvalid_q ? rdata_q : '0;
  assign w_abs   = m[31] ? (32'd0 - m) : m;
  assign acc_abs = acc_q[31] ? (32'd0 - acc_q) : acc_q;
  assign m_abs   = w_abs;
  assign pc_inc  = pc_q + PW'(1);
  assign pc_inc2 = pc_q + PW'(2);
  assign char_v  = m[31] ? (32'd0 - dec_rem_q) : dec_rem_q;
  assign quo_s   = (acc_q[31] ^ m[31]) ? (32'd0 - quo) : quo;
  assign rem_s   = acc_q[31] ? (32'd0 - rem) : rem;
  assign out_free = !out_valid_q || out_ready_i;

  assign div_start = (act_i == dam_pkg::A_DIVST);
  assign dec_start = (act_i == dam_pkg::A_DECST);

  dam_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (acc_abs),
    .divisor_i  (m_abs),
    .done_o     (div_done),
    .quo_o      (quo),
    .rem_o      (rem)
  );

  // word magnitude / 100 or / 1000 by reciprocal multiply: product, quotient,
  // remainder, one stage a cycle
  assign dec_recip = dec_wide_q ? dam_pkg::CHAR_RECIP : dam_pkg::DEC_RECIP;
  assign dec_quo_d = dec_wide_q ? 32'(dec_prod_q >> dam_pkg::CHAR_SHIFT)
                                : 32'(dec_prod_q >> dam_pkg::DEC_SHIFT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dec_stage_q <= '0;
      dec_done_q  <= 1'b0;
    end else begin
      dec_stage_q <= {dec_stage_q[1:0], dec_start};
      dec_done_q  <= dec_stage_q[2];
    end
  end

  always_ff @(posedge clk_i) begin
    if (dec_start) begin
      dec_x_q    <= w_abs;
      dec_wide_q <= (chars_q != 7'd0);
    end
    if (dec_stage_q[0]) begin
      dec_prod_q <= {32'd0, dec_x_q} * {32'd0, dec_recip};
    end
    if (dec_stage_q[1]) begin
      dec_quo_q <= dec_quo_d;
    end
    if (dec_stage_q[2]) begin
      dec_rem_q <= dec_wide_q ? (dec_x_q - dec_quo_q * dam_pkg::CHAR_DIVISOR)
                              : (dec_x_q - dec_quo_q * dam_pkg::DEC_DIVISOR);
    end
  end

  // memory port selection
  always_comb begin
    rd_en = (act_i == dam_pkg::A_RDPC) || (act_i == dam_pkg::A_RDAD);
    ra    = (act_i == dam_pkg::A_RDPC) ? pc_q : ad_q;
    we    = 1'b0;
    wa    = ad_q;
    wd    = acc_q;
    if (act_i == dam_pkg::A_LOAD) begin
      we = 1'b1;
      wa = ld_addr_q;
      wd = ld_val_q;
    end else if (act_i == dam_pkg::A_EXEC && op_q == dam_pkg::OP_READ) begin
      we = 1'b1;
      wd = rd_val_q;
    end else if (act_i == dam_pkg::A_EXEC && op_q == dam_pkg::OP_STORE) begin
      we = 1'b1;
    end
    if (wa >= 7'(dam_pkg::MEM_WORDS)) begin
      we = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[wa[AW-1:0]] <= wd;
    end
    if (rd_en) begin
      rdata_q <= mem_q[ra[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (we) begin
        vld_q[wa[AW-1:0]] <= 1'b1;
      end
      if (rd_en) begin
        rvalid_q <= (ra < 7'(dam_pkg::MEM_WORDS)) && vld_q[ra[AW-1:0]];
      end
    end
  end

  // architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q    <= '0;
      pc_q     <= '0;
      halted_q <= 1'b0;
      chars_q  <= '0;
    end else begin
      case (act_i)
        dam_pkg::A_LOAD: begin
          acc_q    <= '0;
          pc_q     <= '0;
          halted_q <= 1'b0;
          chars_q  <= '0;
        end
        dam_pkg::A_PCOVF: begin
          halted_q <= 1'b1;
          chars_q  <= '0;
        end
        dam_pkg::A_DECFIN: begin
          if (chars_q != 7'd0) begin
            chars_q <= chars_q - 7'd1;
            pc_q    <= (chars_q == 7'd1) ? pc_inc2 : pc_inc;
          end
        end
        dam_pkg::A_EXEC: begin
          case (op_q)
            dam_pkg::OP_READ, dam_pkg::OP_WRITE: pc_q <= pc_inc;
            dam_pkg::OP_LOAD: begin
              acc_q <= m;
              pc_q  <= pc_inc;
            end
            dam_pkg::OP_STORE: begin
              acc_q <= '0;
              pc_q  <= pc_inc;
            end
            dam_pkg::OP_ADD: begin
              acc_q <= acc_q + m;
              pc_q  <= pc_inc;
            end
            dam_pkg::OP_SUB: begin
              acc_q <= acc_q - m;
              pc_q  <= pc_inc;
            end
            dam_pkg::OP_MUL: begin
              acc_q <= acc_q * m;
              pc_q  <= pc_inc;
            end
            dam_pkg::OP_BR:     pc_q <= ad_q;
            dam_pkg::OP_BRNEG:  pc_q <= acc_q[31] ? ad_q : pc_inc;
            dam_pkg::OP_BRZERO: pc_q <= (acc_q == 32'd0) ? ad_q : pc_inc;
            dam_pkg::OP_HALT:   halted_q <= 1'b1;
            dam_pkg::OP_STROUT: begin
              chars_q <= ad_q;
              pc_q    <= (ad_q == 7'd0) ? pc_inc2 : pc_inc;
            end
            default: halted_q <= 1'b1;
          endcase
        end
        dam_pkg::A_DIVFIN: begin
          acc_q <= (op_q == dam_pkg::OP_MOD) ? rem_s : quo_s;
          pc_q  <= pc_inc;
        end
        dam_pkg::A_DIVZ: halted_q <= 1'b1;
        dam_pkg::A_POWFIN: begin
          acc_q <= res_q;
          pc_q  <= pc_inc;
        end
        dam_pkg::A_POWNEG: begin
          if (acc_q == 32'd1) begin
            acc_q <= 32'd1;
          end else if (acc_q == 32'hFFFF_FFFF) begin
            acc_q <= m[0] ? 32'hFFFF_FFFF : 32'd1;
          end else begin
            acc_q <= '0;
          end
          pc_q <= pc_inc;
        end
        default: ;
      endcase
    end
  end

  // item, decode, power and result words
  always_ff @(posedge clk_i) begin
    case (act_i)
      dam_pkg::A_CAPTURE: begin
        kind_q     <= kind_i;
        ld_addr_q  <= load_address_i;
        ld_val_q   <= load_value_i;
        rd_val_q   <= read_value_i;
        r_status_q <= dam_pkg::ST_OK;
        r_val_q    <= '0;
        r_char_q   <= '0;
        r_last_q   <= 1'b0;
      end
      dam_pkg::A_LOAD:  r_status_q <= dam_pkg::ST_LOADED;
      dam_pkg::A_IDLEH: r_status_q <= dam_pkg::ST_IDLEH;
      dam_pkg::A_PCOVF: r_status_q <= dam_pkg::ST_PCOVF;
      dam_pkg::A_DECFIN: begin
        if (chars_q != 7'd0) begin
          r_status_q <= dam_pkg::ST_CHAR;
          r_char_q   <= char_v[7:0];
          r_last_q   <= (chars_q == 7'd1);
        end else begin
          // negative words and huge quotients decode as no valid opcode
          op_q <= (m[31] || (|dec_quo_q[31:7])) ? '0 : dec_quo_q[6:0];
          ad_q <= dec_rem_q[6:0];
        end
      end
      dam_pkg::A_EXEC: begin
        case (op_q)
          dam_pkg::OP_READ: r_status_q <= dam_pkg::ST_READ;
          dam_pkg::OP_WRITE: begin
            r_status_q <= dam_pkg::ST_WROTE;
            r_val_q    <= m;
          end
          dam_pkg::OP_HALT: r_status_q <= dam_pkg::ST_HALT;
          dam_pkg::OP_LOAD, dam_pkg::OP_STORE, dam_pkg::OP_ADD, dam_pkg::OP_SUB,
          dam_pkg::OP_MUL, dam_pkg::OP_BR, dam_pkg::OP_BRNEG, dam_pkg::OP_BRZERO,
          dam_pkg::OP_STROUT: ;
          default: r_status_q <= dam_pkg::ST_BADOP;
        endcase
      end
      dam_pkg::A_DIVZ: r_status_q <= dam_pkg::ST_DIVZ;
      dam_pkg::A_POWINIT: begin
        base_q <= acc_q;
        res_q  <= 32'd1;
        exp_q  <= m;
      end
      dam_pkg::A_POWSTEP: begin
        if (exp_q[0]) begin
          res_q <= res_q * base_q;
        end
        base_q <= base_q * base_q;
        exp_q  <= {1'b0, exp_q[31:1]};
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (act_i == dam_pkg::A_OUT) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (act_i == dam_pkg::A_OUT) begin
      o_status_q <= r_status_q;
      o_val_q    <= r_val_q;
      o_char_q   <= r_char_q;
      o_last_q   <= r_last_q;
      o_pc_q     <= pc_q;
      o_acc_q    <= acc_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = o_status_q;
  assign out_value_o = o_val_q;
  assign out_char_o  = o_char_q;
  assign last_char_o = o_last_q;
  assign pc_now_o    = o_pc_q;
  assign acc_now_o   = o_acc_q;

  always_comb begin
    stat_o.kind     = kind_q;
    stat_o.halted   = halted_q;
    stat_o.chars_nz = (chars_q != 7'd0);
    stat_o.pc_ovf   = (pc_q >= 7'(dam_pkg::MEM_WORDS));
    stat_o.div_done = div_done || dec_done_q;
    stat_o.op       = op_q;
    stat_o.m_zero   = (m == 32'd0);
    stat_o.m_neg    = m[31];
    stat_o.exp_zero = (exp_q == 32'd0);
    stat_o.out_free = out_free;
  end

endmodule
`default_nettype wire

// ----- sv/decimal_accumulator_machine.sv -----
// Decimal accumulator machine: 100 words of 32-bit memory, accumulator and pc.
// Input stream (s_axis): tuser is the item kind, 0 loads one memory word and
// restarts the machine, 1 runs one instruction or gives out one string
// character. Output stream (m_axis): exactly one word per input word, tuser is
// the status code, tlast marks the final character of a string.
// A load, a halted step or a pc overflow skips the fetch; a string character
// and an instruction go through the fetch and the three-stage reciprocal
// multiply that splits the word into opcode and address (or takes it modulo
// 1000), and an instruction then reads its operand. DIVIDE and MODULE add a
// run of the shift-subtract divider; POW adds one step per exponent bit.
// One word is worked on at a time; the next is taken from the cycle after
// the current one enters the output register.
// Reset clears the accumulator, pc, halt flag, string count and all memory
// valid bits, so every word reads as zero until written.
// A stalled receiver holds the result in the output register; one further
// word may be taken and worked on, then the machine waits for it to drain.
`default_nettype none
module decimal_accumulator_machine (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [6:0] load_address, [38:7] load_value, [70:39] read_value, [71] zero
  input  wire logic [71:0] s_axis_tdata,
  // [0] kind
  input  wire logic        s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [31:0] out_value, [39:32] out_char, [46:40] pc_now, [78:47] acc_now, [79] zero
  output logic [79:0]      m_axis_tdata,
  // [3:0] status
  output logic [3:0]       m_axis_tuser,
  output logic             m_axis_tlast
);

  dam_pkg::act_e     act;
  dam_pkg::dp_stat_t stat;
  logic [31:0]       out_value, acc_now;
  logic [7:0]        out_char;
  logic [6:0]        pc_now;

  dam_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .act_o      (act)
  );

  dam_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .act_i          (act),
    .stat_o         (stat),
    .kind_i         (s_axis_tuser),
    .load_address_i (s_axis_tdata[6:0]),
    .load_value_i   (s_axis_tdata[38:7]),
    .read_value_i   (s_axis_tdata[70:39]),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .status_o       (m_axis_tuser),
    .out_value_o    (out_value),
    .out_char_o     (out_char),
    .last_char_o    (m_axis_tlast),
    .pc_now_o       (pc_now),
    .acc_now_o      (acc_now)
  );

  assign m_axis_tdata = {1'b0, acc_now, pc_now, out_char, out_value};

  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while a word is in progress");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tuser <= dam_pkg::ST_IDLEH)
    else $error("status code out of range");

  a_last_is_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser == dam_pkg::ST_CHAR)
    else $error("last flag on a non-character word");

  a_value_only_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != dam_pkg::ST_WROTE |-> m_axis_tdata[31:0] == 32'd0)
    else $error("output value set without WRITE");

endmodule
`default_nettype wire
